/* src/cau_pkg.sv */
`default_nettype none

package cau_pkg;

    // Operation codes carried by the kind field
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam int FIELD_W = 32;               // width of every operand and result port
    localparam int PROD_W  = 2 * FIELD_W;      // exact product of two fields
    localparam int SUM_W   = PROD_W + 1;       // exact sum of two products

endpackage

`default_nettype wire

/* src/complex_arithmetic_unit.sv */
`default_nettype none
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// A request accepted at a clock edge passes the capture, product, combine and divider
// set-up stages, the divider steps and the output register before done goes high.
// Throughput: one request per cycle; busy stays low, one quotient bit per stage.
// The divider's pipeline length (one stage per quotient bit) sets the latency.
// Reset clears every valid bit and the done strobe; data registers are not reset.

module complex_arithmetic_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic signed [31:0] a_re,
    input  wire logic signed [31:0] a_im,
    input  wire logic signed [31:0] b_re,
    input  wire logic signed [31:0] b_im,
    output logic             done,
    output logic signed [31:0] res_re,
    output logic signed [31:0] res_im,
    output logic             divide_by_zero,
    output logic             saturated
);

    // Working word: never wider than the ports
    localparam int EW    = (WORD_BITS > cau_pkg::FIELD_W) ? cau_pkg::FIELD_W : WORD_BITS;
    localparam int SH    = cau_pkg::FIELD_W - EW;
    localparam int MW    = cau_pkg::PROD_W;          // magnitude of a divide numerator
    localparam int NW    = MW + FRAC_BITS;           // numerator after the fraction shift
    localparam int TOPW  = NW - EW;                  // numerator bits above the quotient
    localparam int SW    = cau_pkg::SUM_W;
    localparam int LAT   = EW + 5;

    localparam logic signed [SW-1:0] MAX_V = (SW'(1) <<< (EW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MIN_V = -(SW'(1) <<< (EW - 1));
    localparam logic [EW:0] POS_LIM = (EW + 1)'((64'd1 << (EW - 1)) - 64'd1);
    localparam logic [EW:0] NEG_LIM = (EW + 1)'(64'd1 << (EW - 1));

    // Sign-extend a field from the low EW bits
    function automatic logic signed [31:0] sext(input logic [31:0] x);
        logic signed [31:0] t;
        t = $signed(x << SH);
        return t >>> SH;
    endfunction

    // Clamp an exact value to the word range: {saturated, value}
    function automatic logic [32:0] clamp_w(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        logic                 s;
        s = 1'b0;
        c = v;
        if (v > MAX_V)
        begin
            c = MAX_V;
            s = 1'b1;
        end
        else if (v < MIN_V)
        begin
            c = MIN_V;
            s = 1'b1;
        end
        return {s, c[31:0]};
    endfunction

    // Apply sign and clamp to a quotient: {saturated, value}
    function automatic logic [32:0] div_w(input logic [EW-1:0] q, input logic neg,
                                          input logic ovf);
        logic [EW:0]        lim;
        logic [EW:0]        m;
        logic               s;
        logic signed [32:0] sv;
        lim = neg ? NEG_LIM : POS_LIM;
        s   = ovf || ({1'b0, q} > lim);
        m   = s ? lim : {1'b0, q};
        sv  = neg ? -$signed(33'(m)) : $signed(33'(m));
        return {s, sv[31:0]};
    endfunction

    // The receiver cannot stall, so the pipeline never holds a request off
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture the request
    // ------------------------------------------------------------------
    logic              v1_reg;
    cau_pkg::op_t      k1_reg;
    logic signed [31:0] ar_reg, ai_reg, br_reg, bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg <= cau_pkg::op_t'(kind);
        ar_reg <= sext(a_re);
        ai_reg <= sext(a_im);
        br_reg <= sext(b_re);
        bi_reg <= sext(b_im);
    end

    // ------------------------------------------------------------------
    // Stage 2: six exact products, plus the add/subtract sums
    // ------------------------------------------------------------------
    logic               v2_reg;
    cau_pkg::op_t       k2_reg;
    logic signed [MW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic signed [32:0] s_re_reg, s_im_reg;
    logic signed [32:0] s_re_next, s_im_next;

    always_comb
    begin
        if (k1_reg == cau_pkg::OP_SUB)
        begin
            s_re_next = 33'(ar_reg) - 33'(br_reg);
            s_im_next = 33'(ai_reg) - 33'(bi_reg);
        end
        else
        begin
            s_re_next = 33'(ar_reg) + 33'(br_reg);
            s_im_next = 33'(ai_reg) + 33'(bi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k2_reg   <= k1_reg;
        p_rr_reg <= ar_reg * br_reg;
        p_ii_reg <= ai_reg * bi_reg;
        p_ri_reg <= ar_reg * bi_reg;
        p_ir_reg <= ai_reg * br_reg;
        p_bb_reg <= br_reg * br_reg;
        p_cc_reg <= bi_reg * bi_reg;
        s_re_reg <= s_re_next;
        s_im_reg <= s_im_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: combine products into the exact result or numerator
    // ------------------------------------------------------------------
    logic               v3_reg;
    cau_pkg::op_t       k3_reg;
    logic signed [SW-1:0] val_re_reg, val_im_reg;
    logic signed [SW-1:0] val_re_next, val_im_next;
    logic [MW-1:0]      den3_reg;

    always_comb
    begin
        case (k2_reg)
            cau_pkg::OP_MUL:
            begin
                val_re_next = SW'(p_rr_reg) - SW'(p_ii_reg);
                val_im_next = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            cau_pkg::OP_DIV:
            begin
                val_re_next = SW'(p_rr_reg) + SW'(p_ii_reg);
                val_im_next = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            default:
            begin
                val_re_next = SW'(s_re_reg);
                val_im_next = SW'(s_im_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k3_reg     <= k2_reg;
        val_re_reg <= val_re_next;
        val_im_reg <= val_im_next;
        den3_reg   <= MW'($unsigned(p_bb_reg)) + MW'($unsigned(p_cc_reg));
    end

    // ------------------------------------------------------------------
    // Stage 4: finish add/sub/mul, set up the divider lanes
    // Index 0 of the arrays below is this stage; index k+1 follows divider step k.
    // ------------------------------------------------------------------
    logic           vd_reg   [0:EW];
    logic           div_reg  [0:EW];
    logic           dz_reg   [0:EW];
    logic [MW-1:0]  den_reg  [0:EW];
    logic [32:0]    fin_re_reg [0:EW];
    logic [32:0]    fin_im_reg [0:EW];
    logic           neg_re_reg [0:EW];
    logic           neg_im_reg [0:EW];
    logic           ovf_re_reg [0:EW];
    logic           ovf_im_reg [0:EW];
    logic [MW-1:0]  rem_re_reg [0:EW];
    logic [MW-1:0]  rem_im_reg [0:EW];
    logic [EW-1:0]  low_re_reg [0:EW];
    logic [EW-1:0]  low_im_reg [0:EW];
    logic [EW-1:0]  q_re_reg   [0:EW];
    logic [EW-1:0]  q_im_reg   [0:EW];

    logic signed [SW-1:0] sh_re, sh_im;
    logic [MW-1:0]  mag_re, mag_im;
    logic [NW-1:0]  n_re, n_im;
    logic [TOPW-1:0] top_re, top_im;

    always_comb
    begin
        // floor shift of the product sums; sums pass unshifted
        sh_re  = (k3_reg == cau_pkg::OP_MUL) ? (val_re_reg >>> FRAC_BITS) : val_re_reg;
        sh_im  = (k3_reg == cau_pkg::OP_MUL) ? (val_im_reg >>> FRAC_BITS) : val_im_reg;
        mag_re = val_re_reg[SW-1] ? MW'(-val_re_reg) : MW'(val_re_reg);
        mag_im = val_im_reg[SW-1] ? MW'(-val_im_reg) : MW'(val_im_reg);
        n_re   = NW'(mag_re) << FRAC_BITS;
        n_im   = NW'(mag_im) << FRAC_BITS;
        top_re = n_re[NW-1:EW];
        top_im = n_im[NW-1:EW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg[0] <= 1'b0;
        end
        else
        begin
            vd_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg[0]    <= (k3_reg == cau_pkg::OP_DIV);
        dz_reg[0]     <= (den3_reg == '0);
        den_reg[0]    <= den3_reg;
        fin_re_reg[0] <= clamp_w(sh_re);
        fin_im_reg[0] <= clamp_w(sh_im);
        neg_re_reg[0] <= val_re_reg[SW-1];
        neg_im_reg[0] <= val_im_reg[SW-1];
        // quotient would need more than EW bits
        ovf_re_reg[0] <= (NW'(top_re) >= NW'(den3_reg));
        ovf_im_reg[0] <= (NW'(top_im) >= NW'(den3_reg));
        rem_re_reg[0] <= MW'(top_re);
        rem_im_reg[0] <= MW'(top_im);
        low_re_reg[0] <= n_re[EW-1:0];
        low_im_reg[0] <= n_im[EW-1:0];
        q_re_reg[0]   <= '0;
        q_im_reg[0]   <= '0;
    end

    // ------------------------------------------------------------------
    // Divider: one restoring step per stage, both lanes side by side
    // ------------------------------------------------------------------
    for (genvar k = 0; k < EW; k++)
    begin : g_div
        logic [MW:0]   t_re, t_im;
        logic          ge_re, ge_im;
        logic [MW-1:0] rem_re_next, rem_im_next;

        always_comb
        begin
            t_re        = {rem_re_reg[k], low_re_reg[k][EW-1]};
            t_im        = {rem_im_reg[k], low_im_reg[k][EW-1]};
            ge_re       = (t_re >= {1'b0, den_reg[k]});
            ge_im       = (t_im >= {1'b0, den_reg[k]});
            rem_re_next = ge_re ? MW'(t_re - {1'b0, den_reg[k]}) : t_re[MW-1:0];
            rem_im_next = ge_im ? MW'(t_im - {1'b0, den_reg[k]}) : t_im[MW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[k+1] <= 1'b0;
            end
            else
            begin
                vd_reg[k+1] <= vd_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            div_reg[k+1]    <= div_reg[k];
            dz_reg[k+1]     <= dz_reg[k];
            den_reg[k+1]    <= den_reg[k];
            fin_re_reg[k+1] <= fin_re_reg[k];
            fin_im_reg[k+1] <= fin_im_reg[k];
            neg_re_reg[k+1] <= neg_re_reg[k];
            neg_im_reg[k+1] <= neg_im_reg[k];
            ovf_re_reg[k+1] <= ovf_re_reg[k];
            ovf_im_reg[k+1] <= ovf_im_reg[k];
            rem_re_reg[k+1] <= rem_re_next;
            rem_im_reg[k+1] <= rem_im_next;
            low_re_reg[k+1] <= low_re_reg[k] << 1;
            low_im_reg[k+1] <= low_im_reg[k] << 1;
            q_re_reg[k+1]   <= {q_re_reg[k][EW-2:0], ge_re};
            q_im_reg[k+1]   <= {q_im_reg[k][EW-2:0], ge_im};
        end
    end

    // ------------------------------------------------------------------
    // Output stage: pick the result, apply quotient sign and clamp
    // ------------------------------------------------------------------
    logic              done_reg, dz_out_reg, sat_reg;
    logic signed [31:0] re_reg, im_reg;
    logic [32:0]       qd_re, qd_im;
    logic [31:0]       re_next, im_next;
    logic              sat_next, dz_next;

    always_comb
    begin
        qd_re = div_w(q_re_reg[EW], neg_re_reg[EW], ovf_re_reg[EW]);
        qd_im = div_w(q_im_reg[EW], neg_im_reg[EW], ovf_im_reg[EW]);
        dz_next = 1'b0;
        if (!div_reg[EW])
        begin
            re_next  = fin_re_reg[EW][31:0];
            im_next  = fin_im_reg[EW][31:0];
            sat_next = fin_re_reg[EW][32] || fin_im_reg[EW][32];
        end
        else if (dz_reg[EW])
        begin
            // zero divisor: drop the quotient, flag it
            re_next  = '0;
            im_next  = '0;
            sat_next = 1'b0;
            dz_next  = 1'b1;
        end
        else
        begin
            re_next  = qd_re[31:0];
            im_next  = qd_im[31:0];
            sat_next = qd_re[32] || qd_im[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd_reg[EW];
        end
    end

    always_ff @(posedge clk)
    begin
        re_reg     <= re_next;
        im_reg     <= im_next;
        sat_reg    <= sat_next;
        dz_out_reg <= dz_next;
    end

    assign done           = done_reg;
    assign res_re         = re_reg;
    assign res_im         = im_reg;
    assign divide_by_zero = dz_out_reg;
    assign saturated      = sat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request did not complete after the pipeline latency");

    a_dz_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(divide_by_zero && saturated))
        else $error("zero divisor reported together with saturation");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (res_re == 32'sd0 && res_im == 32'sd0))
        else $error("zero divisor result is not zero");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vd_reg[EW]))
        else $error("result strobe without a request in the last stage");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        cau_pkg::op_t kind;
        logic [31:0]  a_re;
        logic [31:0]  a_im;
        logic [31:0]  b_re;
        logic [31:0]  b_im;
    } request_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } answer_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = '0;
    logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    wire         busy, done, divide_by_zero, saturated;
    wire signed [31:0] res_re, res_im;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       stim_ready = 1'b0;
    int       cycle_no = 0;

    always #1 clk = ~clk;

    complex_arithmetic_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
        .res_re(res_re), .res_im(res_im), .divide_by_zero(divide_by_zero),
        .saturated(saturated)
    );

    // Clamp an exact value to the signed 32-bit range; force clamps when big is set.
    function automatic logic [31:0] clamp32(input logic signed [130:0] v, input bit big,
                                            inout logic sat);
        logic signed [130:0] hi_lim, lo_lim;
        hi_lim = 131'sd2147483647;
        lo_lim = -131'sd2147483648;
        if (big || v > hi_lim || v < lo_lim)
        begin
            sat = 1'b1;
            return (v < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Compute the complex result of one request with exact wide arithmetic.
    function automatic answer_t complex_result(input request_t r);
        logic signed [130:0] ar, ai, br, bi, pr, pi, den, q;
        answer_t ans;
        ar = $signed(r.a_re);
        ai = $signed(r.a_im);
        br = $signed(r.b_re);
        bi = $signed(r.b_im);
        ans = '0;
        case (r.kind)
            cau_pkg::OP_ADD:
            begin
                ans.re = clamp32(ar + br, 1'b0, ans.sat);
                ans.im = clamp32(ai + bi, 1'b0, ans.sat);
            end
            cau_pkg::OP_SUB:
            begin
                ans.re = clamp32(ar - br, 1'b0, ans.sat);
                ans.im = clamp32(ai - bi, 1'b0, ans.sat);
            end
            cau_pkg::OP_MUL:
            begin
                // arithmetic shift floors toward minus infinity
                pr = (ar * br - ai * bi) >>> 16;
                pi = (ar * bi + ai * br) >>> 16;
                ans.re = clamp32(pr, 1'b0, ans.sat);
                ans.im = clamp32(pi, 1'b0, ans.sat);
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    ans.dz = 1'b1;
                else
                begin
                    // signed division truncates toward zero
                    pr = (ar * br + ai * bi) <<< 16;
                    pi = (ai * br - ar * bi) <<< 16;
                    q = pr / den;
                    ans.re = clamp32(q, 1'b0, ans.sat);
                    q = pi / den;
                    ans.im = clamp32(q, 1'b0, ans.sat);
                end
            end
        endcase
        return ans;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'(signed'($urandom_range(0, 8)) - 4);
            4, 5: return 32'(signed'($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
            6: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(input cau_pkg::op_t k, input logic [31:0] ar, ai, br, bi);
        pending_reqs.push_back('{k, ar, ai, br, bi});
    endtask

    initial
    begin
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        // directed: extremes on every operation, zero divisor, tiny divisors
        for (int k = 0; k < 4; k++)
        begin
            push_req(cau_pkg::op_t'(k), mx, mx, mx, mx);
            push_req(cau_pkg::op_t'(k), mn, mn, mn, mn);
            push_req(cau_pkg::op_t'(k), mx, mn, mn, mx);
            push_req(cau_pkg::op_t'(k), 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                     32'hFFFF_0000);
        end
        push_req(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        push_req(cau_pkg::OP_DIV, mx, mn, 32'h0, 32'h0);
        push_req(cau_pkg::OP_DIV, mx, mx, 32'h1, 32'h0);
        push_req(cau_pkg::OP_DIV, mn, 32'h1, 32'h0, 32'hFFFF_FFFF);
        push_req(cau_pkg::OP_DIV, 32'hFFFF_FFFF, 32'h1, 32'h0003_0000, 32'h0);
        push_req(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1);
        push_req(cau_pkg::OP_MUL, 32'h0, 32'h0, 32'h0, 32'h0);
        for (int n = 0; n < 1200; n++)
            push_req(cau_pkg::op_t'($urandom_range(0, 3)), pick_value(), pick_value(),
                     pick_value(), pick_value());
        stim_ready = 1'b1;
    end

    // Driver: hold start while a request waits, except on random idle cycles, and drop it when the queue is dry.
    always @(posedge clk)
    begin
        bit accepted, idle_now;
        request_t r;
        cycle_no <= cycle_no + 1;
        if (cycle_no == 5)
            rst_n <= 1'b1;
        accepted = rst_n && start && !busy;
        if (accepted)
        begin
            r = pending_reqs.pop_front();
            expected_answers.push_back(complex_result(r));
        end
        // no idling between cycles 300 and 900
        idle_now = ($urandom_range(0, 99) < 7) && !(cycle_no > 300 && cycle_no < 900);
        if (rst_n && (accepted || !start))
        begin
            if (stim_ready && pending_reqs.size() > 0 && !idle_now)
            begin
                r = pending_reqs[0];
                start <= 1'b1;
                kind <= r.kind;
                a_re <= r.a_re;
                a_im <= r.a_im;
                b_re <= r.b_re;
                b_im <= r.b_im;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each done strobe against the oldest expectation.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result re=%h im=%h", res_re, res_im);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (res_re !== want.re || res_im !== want.im ||
                    divide_by_zero !== want.dz || saturated !== want.sat)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: want re=%h im=%h dz=%b sat=%b, got %h %h %b %b",
                                 want.re, want.im, want.dz, want.sat,
                                 res_re, res_im, divide_by_zero, saturated);
                end
            end
        end
    end

    // Watchdog: count cycles in which no request and no result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        wait (stim_ready);
        @(posedge clk);
        while (pending_reqs.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
